// File: sv/vss_pkg.sv
// package of the visual-servo steering block: constants, codes, state type
// and the command and status structs shared by controller and datapath
// no dependencies
`default_nettype none

package vss_pkg;

  localparam int COEFF_BITS  = 48;
  localparam int IMAGE_WIDTH = 640;
  localparam int DIST_W      = 20;
  localparam int ID_W        = 16;
  localparam int PIX_W       = 12;
  localparam int VEL_W       = 17;
  localparam int CFG_DATA_W  = 20;
  localparam int ACC_W       = 64;
  localparam int FRAC_BITS   = 16;
  localparam int OVF_SHIFT   = 24;
  localparam int QUOT_W      = OVF_SHIFT + FRAC_BITS;
  localparam int SUM_W       = QUOT_W + 4;
  localparam int CTR_SHIFT   = FRAC_BITS + 2;
  localparam int CTR_W       = SUM_W - CTR_SHIFT;
  localparam int ERR_W       = CTR_W + 1;
  localparam int ANG_W       = ERR_W + 16 - 8;
  localparam int BIT_CNT_W   = 6;

  localparam logic [15:0] ANG_GAIN    = 16'd33554;
  localparam logic [15:0] LIN_GAIN    = 16'd26214;
  localparam logic [15:0] SEARCH_SPIN = 16'd16384;
  localparam logic [ERR_W-1:0] HALF_WIDTH = ERR_W'(IMAGE_WIDTH / 2);

  localparam logic [2:0] ACT_COEFF  = 3'd0;
  localparam logic [2:0] ACT_REPORT = 3'd1;
  localparam logic [2:0] ACT_NONE   = 3'd2;
  localparam logic [2:0] ACT_LEFT   = 3'd3;
  localparam logic [2:0] ACT_RIGHT  = 3'd4;
  localparam logic [2:0] ACT_LIDAR  = 3'd5;

  localparam logic [1:0] MODE_SEARCH = 2'd0;
  localparam logic [1:0] MODE_TURN   = 2'd1;
  localparam logic [1:0] MODE_DRIVE  = 2'd2;
  localparam logic [1:0] MODE_HOLD   = 2'd3;

  localparam logic [2:0] CFG_USE_LIDAR  = 3'd0;
  localparam logic [2:0] CFG_TARGET_ID  = 3'd1;
  localparam logic [2:0] CFG_DIST_TOF   = 3'd2;
  localparam logic [2:0] CFG_DIST_LIDAR = 3'd3;
  localparam logic [2:0] CFG_ANG_DB     = 3'd4;
  localparam logic [2:0] CFG_ANG_LIM    = 3'd5;
  localparam logic [2:0] CFG_LIN_DB     = 3'd6;
  localparam logic [2:0] CFG_LIN_LIM    = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_DIV_INIT,
    ST_DIV_STEP,
    ST_DIV_DONE,
    ST_CENTRE,
    ST_GAIN,
    ST_EMIT,
    ST_SEARCH
  } vss_state_e;

  typedef enum logic [1:0] {
    DOT_W,
    DOT_X,
    DOT_Y
  } vss_dot_e;

  typedef struct packed {
    logic       accept;
    logic       clr_track;
    logic       mul;
    logic       acc;
    logic       acc_first;
    logic       save_wt;
    logic       div_init;
    logic       div_step;
    logic       div_done;
    logic       centre;
    logic       gain;
    logic       emit_track;
    logic       emit_search;
    logic [1:0] corner;
    logic [1:0] term;
    vss_dot_e   dot;
  } vss_cmd_t;

  typedef struct packed {
    logic start_track;
    logic start_search;
    logic div_skip;
    logic out_free;
  } vss_sts_t;

  // coefficient k = row + 3 * column, column = term, row picked by the dot product
  function automatic logic [3:0] coeff_idx(input logic [1:0] term, input vss_dot_e dot);
    logic [3:0] row;
    case (dot)
      DOT_X:   row = 4'd0;
      DOT_Y:   row = 4'd1;
      default: row = 4'd2;
    endcase
    return 4'({2'b00, term} * 4'd3) + row;
  endfunction

endpackage

`default_nettype wire

// File: sv/vss_ctrl.sv
// controller of the visual-servo steering block: sequences dot products,
// the shared divider and the command stage; uses vss_pkg
`default_nettype none

module vss_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire vss_pkg::vss_sts_t sts_i,
  output vss_pkg::vss_cmd_t     cmd_o
);

  vss_pkg::vss_state_e state_q, state_d;
  logic [1:0] corner_q, corner_d;
  logic [1:0] term_q, term_d;
  vss_pkg::vss_dot_e dot_q, dot_d;
  logic [vss_pkg::BIT_CNT_W-1:0] bit_q, bit_d;
  logic accept;

  assign accept     = in_valid_i && (state_q == vss_pkg::ST_IDLE);
  assign in_stall_o = (state_q != vss_pkg::ST_IDLE);

  // next state and counters
  always_comb begin
    state_d  = state_q;
    corner_d = corner_q;
    term_d   = term_q;
    dot_d    = dot_q;
    bit_d    = bit_q;
    case (state_q)
      vss_pkg::ST_IDLE: begin
        if (accept && sts_i.start_track) begin
          state_d  = vss_pkg::ST_MUL;
          corner_d = 2'd0;
          term_d   = 2'd0;
          dot_d    = vss_pkg::DOT_W;
        end else if (accept && sts_i.start_search) begin
          state_d = vss_pkg::ST_SEARCH;
        end
      end
      vss_pkg::ST_MUL: state_d = vss_pkg::ST_ACC;
      vss_pkg::ST_ACC: begin
        if (term_q != 2'd2) begin
          term_d  = term_q + 2'd1;
          state_d = vss_pkg::ST_MUL;
        end else if (dot_q == vss_pkg::DOT_W) begin
          term_d  = 2'd0;
          dot_d   = vss_pkg::DOT_X;
          state_d = vss_pkg::ST_MUL;
        end else begin
          state_d = vss_pkg::ST_DIV_INIT;
        end
      end
      vss_pkg::ST_DIV_INIT: begin
        bit_d   = '0;
        state_d = sts_i.div_skip ? vss_pkg::ST_DIV_DONE : vss_pkg::ST_DIV_STEP;
      end
      vss_pkg::ST_DIV_STEP: begin
        bit_d = bit_q + 1'b1;
        if (bit_q == vss_pkg::BIT_CNT_W'(vss_pkg::QUOT_W - 1)) begin
          state_d = vss_pkg::ST_DIV_DONE;
        end
      end
      vss_pkg::ST_DIV_DONE: begin
        term_d = 2'd0;
        if (dot_q == vss_pkg::DOT_X) begin
          dot_d   = vss_pkg::DOT_Y;
          state_d = vss_pkg::ST_MUL;
        end else if (corner_q == 2'd3) begin
          state_d = vss_pkg::ST_CENTRE;
        end else begin
          corner_d = corner_q + 2'd1;
          dot_d    = vss_pkg::DOT_W;
          state_d  = vss_pkg::ST_MUL;
        end
      end
      vss_pkg::ST_CENTRE: state_d = vss_pkg::ST_GAIN;
      vss_pkg::ST_GAIN:   state_d = vss_pkg::ST_EMIT;
      vss_pkg::ST_EMIT: begin
        if (sts_i.out_free) begin
          state_d = vss_pkg::ST_IDLE;
        end
      end
      vss_pkg::ST_SEARCH: begin
        if (sts_i.out_free) begin
          state_d = vss_pkg::ST_IDLE;
        end
      end
      default: state_d = vss_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o           = '0;
    cmd_o.corner    = corner_q;
    cmd_o.term      = term_q;
    cmd_o.dot       = dot_q;
    cmd_o.accept    = accept;
    cmd_o.clr_track = accept && sts_i.start_track;
    case (state_q)
      vss_pkg::ST_MUL: cmd_o.mul = 1'b1;
      vss_pkg::ST_ACC: begin
        cmd_o.acc       = 1'b1;
        cmd_o.acc_first = (term_q == 2'd0);
        cmd_o.save_wt   = (term_q == 2'd2) && (dot_q == vss_pkg::DOT_W);
      end
      vss_pkg::ST_DIV_INIT: cmd_o.div_init    = 1'b1;
      vss_pkg::ST_DIV_STEP: cmd_o.div_step    = 1'b1;
      vss_pkg::ST_DIV_DONE: cmd_o.div_done    = 1'b1;
      vss_pkg::ST_CENTRE:   cmd_o.centre      = 1'b1;
      vss_pkg::ST_GAIN:     cmd_o.gain        = 1'b1;
      vss_pkg::ST_EMIT:     cmd_o.emit_track  = sts_i.out_free;
      vss_pkg::ST_SEARCH:   cmd_o.emit_search = sts_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= vss_pkg::ST_IDLE;
      corner_q <= '0;
      term_q   <= '0;
      dot_q    <= vss_pkg::DOT_W;
      bit_q    <= '0;
    end else begin
      state_q  <= state_d;
      corner_q <= corner_d;
      term_q   <= term_d;
      dot_q    <= dot_d;
      bit_q    <= bit_d;
    end
  end

endmodule

`default_nettype wire

// File: sv/vss_dp.sv
// datapath of the visual-servo steering block: registers, coefficient store,
// multiplier, shared restoring divider and output register; uses vss_pkg
`default_nettype none

module vss_dp (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [2:0]                     cfg_index_i,
  input  wire logic [vss_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic [2:0]                     action_i,
  input  wire logic [3:0]                     coeff_index_i,
  input  wire logic signed [vss_pkg::COEFF_BITS-1:0] coeff_value_i,
  input  wire logic [vss_pkg::DIST_W-1:0]     distance_i,
  input  wire logic                           scan_last_i,
  input  wire logic [vss_pkg::ID_W-1:0]       object_id_i,
  input  wire logic [vss_pkg::PIX_W-1:0]      object_width_i,
  input  wire logic [vss_pkg::PIX_W-1:0]      object_height_i,
  input  wire vss_pkg::vss_cmd_t              cmd_i,
  output vss_pkg::vss_sts_t                   sts_o,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic signed [vss_pkg::VEL_W-1:0]    linear_vel_o,
  output logic signed [vss_pkg::VEL_W-1:0]    angular_vel_o,
  output logic signed [15:0]                  center_x_o,
  output logic signed [15:0]                  center_y_o,
  output logic [1:0]                          mode_o
);

  localparam int PROD_W = vss_pkg::COEFF_BITS + vss_pkg::PIX_W + 1;

  // configuration
  logic                          use_lidar_q;
  logic [vss_pkg::ID_W-1:0]      target_id_q;
  logic [vss_pkg::DIST_W-1:0]    dist_tof_q, dist_lidar_q;
  logic [15:0]                   ang_db_q, ang_lim_q, lin_db_q, lin_lim_q;

  // ranges
  logic [vss_pkg::DIST_W-1:0]    left_q, right_q, lidar_min_q, run_min_q, new_min;

  // tracking datapath
  logic signed [vss_pkg::COEFF_BITS-1:0] homog_q [9];
  logic [vss_pkg::PIX_W-1:0]     w_q, h_q;
  logic signed [vss_pkg::PIX_W:0] operand;
  logic signed [PROD_W-1:0]      prod_q;
  logic signed [vss_pkg::ACC_W-1:0] acc_q, wt_q, acc_sum;
  logic [vss_pkg::ACC_W-1:0]     mn, md, md_q, rem_q;
  logic [vss_pkg::ACC_W:0]       rem_sh, rem_sub;
  logic                          div_ovf, div_zero, neg_q, cap_q, ge;
  logic [vss_pkg::QUOT_W-1:0]    dvd_q;
  logic [vss_pkg::QUOT_W:0]      qmag;
  logic signed [vss_pkg::QUOT_W+1:0] qsig;
  logic signed [vss_pkg::SUM_W-1:0]  sx_q, sy_q;
  logic signed [vss_pkg::CTR_W-1:0]  cx_q, cy_q, cx_n, cy_n;
  logic signed [vss_pkg::ERR_W-1:0]  err;
  logic [vss_pkg::ERR_W-1:0]     err_mag;
  logic [vss_pkg::ANG_W-1:0]     ang_q;
  logic                          ang_neg_q, lin_neg_q;
  logic [vss_pkg::DIST_W-1:0]    avg, desired, lin_q, dmag;
  logic signed [vss_pkg::DIST_W:0] derr;
  logic [vss_pkg::DIST_W+15:0]   lin_prod;
  logic [vss_pkg::ERR_W+15:0]    ang_prod;
  logic [15:0]                   ang_mag, lin_mag;

  // output register
  logic                          out_valid_q;
  logic signed [vss_pkg::VEL_W-1:0] lin_out_q, ang_out_q;
  logic signed [15:0]            cx_out_q, cy_out_q;
  logic [1:0]                    mode_q;

  function automatic logic signed [15:0] sat16(input logic signed [vss_pkg::CTR_W-1:0] v);
    if (v > vss_pkg::CTR_W'(32767)) begin
      return 16'sd32767;
    end else if (v < -vss_pkg::CTR_W'(32768)) begin
      return -16'sd32768;
    end
    return v[15:0];
  endfunction

  function automatic logic signed [vss_pkg::CTR_W-1:0] centre_of(
      input logic signed [vss_pkg::SUM_W-1:0] s);
    logic signed [vss_pkg::SUM_W-1:0] adj;
    // truncate toward zero
    adj = s + (s[vss_pkg::SUM_W-1] ? vss_pkg::SUM_W'((1 << vss_pkg::CTR_SHIFT) - 1)
                                   : vss_pkg::SUM_W'(0));
    return adj[vss_pkg::SUM_W-1:vss_pkg::CTR_SHIFT];
  endfunction

  assign sts_o.start_track  = (action_i == vss_pkg::ACT_REPORT) && (object_id_i == target_id_q);
  assign sts_o.start_search = (action_i == vss_pkg::ACT_NONE) ||
                              ((action_i == vss_pkg::ACT_REPORT) && (object_id_i != target_id_q));
  assign sts_o.out_free     = !out_valid_q || !out_stall_i;
  assign sts_o.div_skip     = div_zero || div_ovf;

  // corner operand: bit 0 of the corner picks width, bit 1 picks height
  always_comb begin
    case (cmd_i.term)
      2'd0:    operand = cmd_i.corner[0] ? $signed({1'b0, w_q}) : '0;
      2'd1:    operand = cmd_i.corner[1] ? $signed({1'b0, h_q}) : '0;
      default: operand = (vss_pkg::PIX_W + 1)'(1);
    endcase
  end

  assign acc_sum = (cmd_i.acc_first ? vss_pkg::ACC_W'(0) : acc_q) + vss_pkg::ACC_W'(prod_q);

  // divider set-up
  assign mn       = acc_q[vss_pkg::ACC_W-1] ? vss_pkg::ACC_W'(-acc_q) : vss_pkg::ACC_W'(acc_q);
  assign md       = wt_q[vss_pkg::ACC_W-1] ? vss_pkg::ACC_W'(-wt_q) : vss_pkg::ACC_W'(wt_q);
  assign div_zero = (md == '0);
  assign div_ovf  = (mn >> vss_pkg::OVF_SHIFT) >= md;

  assign rem_sh  = {rem_q, dvd_q[vss_pkg::QUOT_W-1]};
  assign rem_sub = rem_sh - {1'b0, md_q};
  assign ge      = rem_sh >= {1'b0, md_q};

  assign qmag = cap_q ? (vss_pkg::QUOT_W + 1)'(1) << vss_pkg::QUOT_W : {1'b0, dvd_q};
  assign qsig = neg_q ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});

  assign cx_n = centre_of(sx_q);
  assign cy_n = centre_of(sy_q);

  assign err      = vss_pkg::HALF_WIDTH - vss_pkg::ERR_W'(cx_q);
  assign err_mag  = err[vss_pkg::ERR_W-1] ? vss_pkg::ERR_W'(-err) : vss_pkg::ERR_W'(err);
  assign ang_prod = err_mag * vss_pkg::ANG_GAIN;

  assign avg     = use_lidar_q ? lidar_min_q
                 : vss_pkg::DIST_W'(({1'b0, left_q} + {1'b0, right_q}) >> 1);
  assign desired = use_lidar_q ? dist_lidar_q : dist_tof_q;
  assign derr    = $signed({1'b0, avg}) - $signed({1'b0, desired});
  assign dmag    = derr[vss_pkg::DIST_W] ? vss_pkg::DIST_W'(-derr) : vss_pkg::DIST_W'(derr);
  assign lin_prod = dmag * vss_pkg::LIN_GAIN;

  assign ang_mag = (ang_q > vss_pkg::ANG_W'(ang_lim_q)) ? ang_lim_q : ang_q[15:0];
  assign lin_mag = (lin_q > vss_pkg::DIST_W'(lin_lim_q)) ? lin_lim_q : lin_q[15:0];

  assign new_min = (distance_i < run_min_q) ? distance_i : run_min_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_lidar_q  <= 1'b0;
      target_id_q  <= 16'd5;
      dist_tof_q   <= 20'd45875;
      dist_lidar_q <= 20'd108134;
      ang_db_q     <= 16'd6554;
      ang_lim_q    <= 16'd16384;
      lin_db_q     <= 16'd3277;
      lin_lim_q    <= 16'd26214;
      left_q       <= '0;
      right_q      <= '0;
      lidar_min_q  <= '0;
      run_min_q    <= '1;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          vss_pkg::CFG_USE_LIDAR:  use_lidar_q  <= cfg_data_i[0];
          vss_pkg::CFG_TARGET_ID:  target_id_q  <= cfg_data_i[15:0];
          vss_pkg::CFG_DIST_TOF:   dist_tof_q   <= cfg_data_i;
          vss_pkg::CFG_DIST_LIDAR: dist_lidar_q <= cfg_data_i;
          vss_pkg::CFG_ANG_DB:     ang_db_q     <= cfg_data_i[15:0];
          vss_pkg::CFG_ANG_LIM:    ang_lim_q    <= cfg_data_i[15:0];
          vss_pkg::CFG_LIN_DB:     lin_db_q     <= cfg_data_i[15:0];
          vss_pkg::CFG_LIN_LIM:    lin_lim_q    <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (cmd_i.accept) begin
        case (action_i)
          vss_pkg::ACT_LEFT:  left_q <= distance_i;
          vss_pkg::ACT_RIGHT: right_q <= distance_i;
          vss_pkg::ACT_LIDAR: begin
            if (scan_last_i) begin
              lidar_min_q <= new_min;
              run_min_q   <= '1;
            end else begin
              run_min_q <= new_min;
            end
          end
          default: ;
        endcase
      end
      if (cmd_i.emit_track || cmd_i.emit_search) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && (action_i == vss_pkg::ACT_COEFF) && (coeff_index_i < 4'd9)) begin
      homog_q[coeff_index_i] <= coeff_value_i;
    end
    if (cmd_i.clr_track) begin
      w_q  <= object_width_i;
      h_q  <= object_height_i;
      sx_q <= '0;
      sy_q <= '0;
    end
    if (cmd_i.mul) begin
      prod_q <= homog_q[vss_pkg::coeff_idx(cmd_i.term, cmd_i.dot)] * operand;
    end
    if (cmd_i.acc) begin
      acc_q <= acc_sum;
    end
    if (cmd_i.save_wt) begin
      wt_q <= acc_sum;
    end
    if (cmd_i.div_init) begin
      md_q  <= md;
      neg_q <= acc_q[vss_pkg::ACC_W-1] ^ wt_q[vss_pkg::ACC_W-1];
      cap_q <= !div_zero && div_ovf;
      rem_q <= mn >> (vss_pkg::QUOT_W - vss_pkg::FRAC_BITS);
      dvd_q <= div_zero ? '0
               : {mn[vss_pkg::OVF_SHIFT-1:0], vss_pkg::FRAC_BITS'(0)};
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? rem_sub[vss_pkg::ACC_W-1:0] : rem_sh[vss_pkg::ACC_W-1:0];
      dvd_q <= {dvd_q[vss_pkg::QUOT_W-2:0], ge};
    end
    if (cmd_i.div_done) begin
      if (cmd_i.dot == vss_pkg::DOT_X) begin
        sx_q <= sx_q + vss_pkg::SUM_W'(qsig);
      end else begin
        sy_q <= sy_q + vss_pkg::SUM_W'(qsig);
      end
    end
    if (cmd_i.centre) begin
      cx_q <= cx_n;
      cy_q <= cy_n;
    end
    if (cmd_i.gain) begin
      ang_q     <= ang_prod[vss_pkg::ERR_W+15:8];
      ang_neg_q <= err[vss_pkg::ERR_W-1];
      lin_q     <= lin_prod[vss_pkg::DIST_W+15:16];
      lin_neg_q <= derr[vss_pkg::DIST_W];
    end
    if (cmd_i.emit_search) begin
      lin_out_q <= '0;
      ang_out_q <= vss_pkg::VEL_W'(vss_pkg::SEARCH_SPIN);
      cx_out_q  <= '0;
      cy_out_q  <= '0;
      mode_q    <= vss_pkg::MODE_SEARCH;
    end else if (cmd_i.emit_track) begin
      cx_out_q <= sat16(cx_q);
      cy_out_q <= sat16(cy_q);
      if (ang_q >= vss_pkg::ANG_W'(ang_db_q)) begin
        lin_out_q <= '0;
        ang_out_q <= ang_neg_q ? -$signed({1'b0, ang_mag}) : $signed({1'b0, ang_mag});
        mode_q    <= vss_pkg::MODE_TURN;
      end else if (lin_q >= vss_pkg::DIST_W'(lin_db_q)) begin
        lin_out_q <= lin_neg_q ? -$signed({1'b0, lin_mag}) : $signed({1'b0, lin_mag});
        ang_out_q <= '0;
        mode_q    <= vss_pkg::MODE_DRIVE;
      end else begin
        lin_out_q <= '0;
        ang_out_q <= '0;
        mode_q    <= vss_pkg::MODE_HOLD;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign linear_vel_o  = lin_out_q;
  assign angular_vel_o = ang_out_q;
  assign center_x_o    = cx_out_q;
  assign center_y_o    = cy_out_q;
  assign mode_o        = mode_q;

endmodule

`default_nettype wire

// File: sv/visual_servo_steering_top.sv
// top level of the visual-servo steering block
// instantiates vss_ctrl and vss_dp; uses vss_pkg
`default_nettype none

// Steering controller for following an object seen by a camera. An input
// transaction either loads one of nine homography coefficients, stores a left
// or right time-of-flight range, feeds a lidar sample (the scan minimum is
// latched on the last sample), or reports an object. Only reports (action 1)
// and nothing-seen (action 2) produce an output transaction. Storage and
// range transactions do not stall the input. A report of another object or
// nothing seen enters a search state that offers the fixed search spin once
// the output register is free; input is stalled in that state. A report of
// the followed object maps four corners through the homography with a single
// shared multiplier and a shared restoring divider that retires one quotient
// bit per cycle: per corner, a weight dot product and x and y dot products
// each followed by a 40-bit division, so eight divisions per report; the
// divider skips ahead on a zero homogeneous term or a quotient that saturates.
// Input is stalled while a report is being worked on; a finished result sits
// in the output register, so the next transaction can enter meanwhile. Every
// coefficient must be written before the first report uses it.
module visual_servo_steering_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration writes
  input  wire logic                           cfg_we_i,
  input  wire logic [2:0]                     cfg_index_i,
  input  wire logic [vss_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input transactions
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [2:0]                     action_i,
  input  wire logic [3:0]                     coeff_index_i,
  input  wire logic signed [vss_pkg::COEFF_BITS-1:0] coeff_value_i,
  input  wire logic [vss_pkg::DIST_W-1:0]     distance_i,
  input  wire logic                           scan_last_i,
  input  wire logic [vss_pkg::ID_W-1:0]       object_id_i,
  input  wire logic [vss_pkg::PIX_W-1:0]      object_width_i,
  input  wire logic [vss_pkg::PIX_W-1:0]      object_height_i,
  // output transactions
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic signed [vss_pkg::VEL_W-1:0]    linear_vel_o,
  output logic signed [vss_pkg::VEL_W-1:0]    angular_vel_o,
  output logic signed [15:0]                  center_x_o,
  output logic signed [15:0]                  center_y_o,
  output logic [1:0]                          mode_o
);

  vss_pkg::vss_cmd_t cmd;
  vss_pkg::vss_sts_t sts;

  // sequencer: dot products, divisions, centre, gains, emit
  vss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // registers, arithmetic and output register
  vss_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .action_i        (action_i),
    .coeff_index_i   (coeff_index_i),
    .coeff_value_i   (coeff_value_i),
    .distance_i      (distance_i),
    .scan_last_i     (scan_last_i),
    .object_id_i     (object_id_i),
    .object_width_i  (object_width_i),
    .object_height_i (object_height_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .linear_vel_o    (linear_vel_o),
    .angular_vel_o   (angular_vel_o),
    .center_x_o      (center_x_o),
    .center_y_o      (center_y_o),
    .mode_o          (mode_o)
  );

endmodule

`default_nettype wire

// File: sv/vss_checker.sv
// port checker for visual_servo_steering_top and its bind statement
// uses vss_pkg for widths and mode codes
`default_nettype none

module vss_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire logic signed [vss_pkg::VEL_W-1:0] linear_vel_o,
  input wire logic signed [vss_pkg::VEL_W-1:0] angular_vel_o,
  input wire logic signed [15:0]          center_x_o,
  input wire logic signed [15:0]          center_y_o,
  input wire logic [1:0]                  mode_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output transaction dropped while stalled");

  // search spin is fixed
  a_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (mode_o == vss_pkg::MODE_SEARCH) |->
      (linear_vel_o == '0) && (angular_vel_o == 17'sd16384) &&
      (center_x_o == '0) && (center_y_o == '0))
    else $error("search result not the fixed spin");

  a_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (mode_o == vss_pkg::MODE_TURN) |-> (linear_vel_o == '0))
    else $error("turning with forward speed");

  a_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (mode_o == vss_pkg::MODE_DRIVE) |-> (angular_vel_o == '0))
    else $error("driving with turn rate");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (mode_o == vss_pkg::MODE_HOLD) |->
      (angular_vel_o == '0) && (linear_vel_o == '0))
    else $error("holding still with a command");

endmodule

bind visual_servo_steering_top vss_checker u_vss_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .linear_vel_o  (linear_vel_o),
  .angular_vel_o (angular_vel_o),
  .center_x_o    (center_x_o),
  .center_y_o    (center_y_o),
  .mode_o        (mode_o)
);

`default_nettype wire
